/* rtl/deadline_timer_queue_top_defines.svh */
// assertion macros for the deadline timer queue
`ifndef DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH

// property must hold at every clock edge outside reset
`define DTQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen outside reset
`define DTQ_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* rtl/dtq_pkg.sv */
// shared types and constants of the deadline timer queue
`default_nettype none

package dtq_pkg;

    localparam int CAPACITY        = 32;
    localparam int TIME_BITS       = 32;
    localparam int QUEUE_ID_BITS   = 8;
    localparam int WORK_ID_BITS    = 16;
    localparam int COUNT_BITS      = $clog2(CAPACITY + 1);
    localparam int GROUP_SIZE      = 8;
    localparam int GROUPS          = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GROUP_BITS      = $clog2(GROUP_SIZE + 1);
    localparam int CFG_DATA_BITS   = (TIME_BITS > QUEUE_ID_BITS) ? TIME_BITS : QUEUE_ID_BITS;
    localparam int IDLE_WAIT_RESET = 30000;

    typedef enum logic [0:0] {
        OP_SCHEDULE = 1'b0,
        OP_TICK     = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_SCHEDULE = 2'd0,
        KIND_DISPATCH = 2'd1,
        KIND_STATUS   = 2'd2
    } kind_t;

    typedef enum logic [0:0] {
        CFG_DEFAULT_QUEUE = 1'b0,
        CFG_IDLE_WAIT     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]     due;
        logic [QUEUE_ID_BITS-1:0] queue;
        logic [WORK_ID_BITS-1:0]  work;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctl_t;

    typedef struct packed {
        op_t                      operation;
        logic [TIME_BITS-1:0]     due_time;
        logic [TIME_BITS-1:0]     current_time;
        logic [QUEUE_ID_BITS-1:0] dest_queue;
        logic                     dest_queue_valid;
        logic                     use_default_queue;
        logic [WORK_ID_BITS-1:0]  work_ident;
        logic                     work_valid;
    } in_item_t;

    typedef struct packed {
        kind_t                    kind;
        logic [QUEUE_ID_BITS-1:0] out_queue;
        logic [WORK_ID_BITS-1:0]  out_work;
        logic                     accepted;
        logic                     became_earliest;
        logic                     queue_full;
        logic [TIME_BITS-1:0]     wake_time;
        logic [COUNT_BITS-1:0]    pending_count;
        logic                     last;
    } out_item_t;

endpackage

`default_nettype wire

/* rtl/deadline_timer_queue_top.sv */
// Deadline timer queue: up to 32 pending entries held in a chain of cells kept sorted by due
// time, equal due times in order of arrival. A schedule item is accepted in the idle state
// and answered from the schedule state once the output is free, the insert being one
// parallel shift of the chain. A tick passes the count states CNT1 and CNT2 for the
// registered count of due cells, then releases each due entry as the chain shifts toward
// its head, then the status result. One item is worked on at a time; results wait in an
// output register while the consumer stalls. Configuration writes are taken in every cycle.
`default_nettype none
`include "deadline_timer_queue_top_defines.svh"

module deadline_timer_queue_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire dtq_pkg::in_item_t                   s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output dtq_pkg::out_item_t                       m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire dtq_pkg::cfg_index_t                 cfg_index,
    input  wire logic [dtq_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int CAP = dtq_pkg::CAPACITY;
    localparam int CB  = dtq_pkg::COUNT_BITS;
    localparam int TB  = dtq_pkg::TIME_BITS;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCHED = 7'b0000010,
        ST_CNT1  = 7'b0000100,
        ST_CNT2  = 7'b0001000,
        ST_POP   = 7'b0010000,
        ST_STAT  = 7'b0100000,
        ST_SPARE = 7'b1000000
    } state_t;

    state_t                            state_reg, state_next;
    dtq_pkg::in_item_t                 item_reg;
    logic [CB-1:0]                     count_reg, count_next;
    logic [CB-1:0]                     release_left_reg, release_left_next;
    logic [CB-1:0]                     remain_reg, remain_next;
    logic                              m_valid_reg, m_valid_next;
    dtq_pkg::out_item_t                m_data_reg, m_data_next;
    logic [dtq_pkg::QUEUE_ID_BITS-1:0] default_queue_reg;
    logic [TB-1:0]                     idle_wait_reg;

    dtq_pkg::entry_t    cell_entry [CAP];
    logic [CAP-1:0]     cell_stays;
    logic [CAP-1:0]     cell_due;
    logic [CAP-1:0]     occ;
    dtq_pkg::entry_t    new_entry;
    dtq_pkg::cell_ctl_t ctl;
    logic [CB-1:0]      due_total;
    logic               out_free;
    logic               sched_ok;
    logic               full;
    logic               early;
    logic [TB:0]        wake_sum;
    logic [TB-1:0]      idle_wake;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_queue_reg <= '0;
            idle_wait_reg     <= TB'(dtq_pkg::IDLE_WAIT_RESET);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dtq_pkg::CFG_DEFAULT_QUEUE: begin
                    default_queue_reg <= cfg_data[dtq_pkg::QUEUE_ID_BITS-1:0];
                end
                dtq_pkg::CFG_IDLE_WAIT: begin
                    idle_wait_reg <= cfg_data[TB-1:0];
                end
            endcase
        end
    end

    // schedule decode
    always_comb begin
        sched_ok        = (item_reg.dest_queue_valid || item_reg.use_default_queue)
                          && item_reg.work_valid;
        full            = (count_reg >= CB'(CAP));
        early           = (count_reg == '0) || (item_reg.due_time < cell_entry[0].due);
        new_entry.due   = item_reg.due_time;
        new_entry.queue = item_reg.use_default_queue ? default_queue_reg : item_reg.dest_queue;
        new_entry.work  = item_reg.work_ident;
        wake_sum        = {1'b0, item_reg.current_time} + {1'b0, idle_wait_reg};
        idle_wake       = wake_sum[TB] ? '1 : wake_sum[TB-1:0];
    end

    always_comb begin
        ctl.insert = (state_reg == ST_SCHED) && out_free && sched_ok && !full;
        ctl.pop    = (state_reg == ST_POP) && out_free && (release_left_reg != '0);
    end

    // sorted cell chain
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        dtq_pkg::entry_t left_e;
        dtq_pkg::entry_t right_e;
        logic            left_s;

        if (i == 0) begin : g_head
            assign left_e = new_entry;
            assign left_s = 1'b1;
        end else begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_s = cell_stays[i-1];
        end

        if (i == CAP - 1) begin : g_tail
            assign right_e = cell_entry[i];
        end else begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        assign occ[i] = (CB'(i) < count_reg);

        dtq_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .occupied    (occ[i]),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_stays  (left_s),
            .right_entry (right_e),
            .now_time    (item_reg.current_time),
            .cur_entry   (cell_entry[i]),
            .stays       (cell_stays[i]),
            .is_due      (cell_due[i])
        );
    end

    dtq_due_count u_due_count (
        .aclk  (aclk),
        .flags (cell_due),
        .total (due_total)
    );

    // sequencer
    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        release_left_next = release_left_reg;
        remain_next       = remain_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.operation == dtq_pkg::OP_TICK) ? ST_CNT1 : ST_SCHED;
                end
            end
            ST_SCHED: begin
                if (out_free) begin
                    m_data_next      = '0;
                    m_data_next.kind = dtq_pkg::KIND_SCHEDULE;
                    m_data_next.last = 1'b1;
                    if (sched_ok && full) begin
                        m_data_next.queue_full = 1'b1;
                    end else if (sched_ok) begin
                        m_data_next.accepted        = 1'b1;
                        m_data_next.became_earliest = early;
                        count_next                  = count_reg + CB'(1);
                    end
                    m_data_next.pending_count = count_next;
                    m_valid_next              = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            ST_CNT1: begin
                state_next = ST_CNT2;
            end
            ST_CNT2: begin
                release_left_next = due_total;
                remain_next       = count_reg - due_total;
                state_next        = ST_POP;
            end
            ST_POP: begin
                if (release_left_reg == '0) begin
                    state_next = ST_STAT;
                end else if (out_free) begin
                    m_data_next               = '0;
                    m_data_next.kind          = dtq_pkg::KIND_DISPATCH;
                    m_data_next.out_queue     = cell_entry[0].queue;
                    m_data_next.out_work      = cell_entry[0].work;
                    m_data_next.pending_count = remain_reg;
                    m_valid_next              = 1'b1;
                    count_next                = count_reg - CB'(1);
                    release_left_next         = release_left_reg - CB'(1);
                end
            end
            ST_STAT: begin
                if (out_free) begin
                    m_data_next               = '0;
                    m_data_next.kind          = dtq_pkg::KIND_STATUS;
                    m_data_next.wake_time     = (count_reg != '0) ? cell_entry[0].due
                                                                  : idle_wake;
                    m_data_next.pending_count = count_reg;
                    m_data_next.last          = 1'b1;
                    m_valid_next              = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        release_left_reg <= release_left_next;
        remain_reg       <= remain_next;
        m_data_reg       <= m_data_next;
    end

    `DTQ_NEVER(a_count_range, aclk, aresetn, count_reg > CB'(CAP), "entry count above capacity")
    `DTQ_ASSERT(a_head_due, aclk, aresetn, (state_reg == ST_POP && release_left_reg != '0) |-> cell_due[0], "released head not due")
    `DTQ_ASSERT(a_remain_match, aclk, aresetn, (state_reg == ST_STAT) |-> (count_reg == remain_reg), "pending count mismatch after release")

    for (genvar i = 0; i < CAP - 1; i++) begin : g_order_chk
        `DTQ_ASSERT(a_sorted, aclk, aresetn, occ[i+1] |-> (cell_entry[i].due <= cell_entry[i+1].due), "cell chain out of order")
    end

endmodule

`default_nettype wire

/* rtl/dtq_cell.sv */
// one cell of the sorted entry chain
`default_nettype none

module dtq_cell (
    input  wire logic               aclk,
    input  wire dtq_pkg::cell_ctl_t ctl,
    input  wire logic               occupied,
    input  wire dtq_pkg::entry_t    new_entry,
    input  wire dtq_pkg::entry_t    left_entry,
    input  wire logic               left_stays,
    input  wire dtq_pkg::entry_t    right_entry,
    input  wire logic [dtq_pkg::TIME_BITS-1:0] now_time,
    output dtq_pkg::entry_t         cur_entry,
    output logic                    stays,
    output logic                    is_due
);

    dtq_pkg::entry_t entry_reg;
    dtq_pkg::entry_t entry_next;

    // equal due times keep the older entry in front
    always_comb begin
        stays  = occupied && (entry_reg.due <= new_entry.due);
        is_due = occupied && (entry_reg.due <= now_time);
    end

    always_comb begin
        entry_next = entry_reg;
        if (ctl.insert && !stays) begin
            entry_next = left_stays ? new_entry : left_entry;
        end else if (ctl.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign cur_entry = entry_reg;

endmodule

`default_nettype wire

/* rtl/dtq_due_count.sv */
// registered tree counting the due cells
`default_nettype none

module dtq_due_count (
    input  wire logic                            aclk,
    input  wire logic [dtq_pkg::CAPACITY-1:0]    flags,
    output logic      [dtq_pkg::COUNT_BITS-1:0]  total
);

    localparam int PAD_BITS = dtq_pkg::GROUPS * dtq_pkg::GROUP_SIZE;
    localparam int GB       = dtq_pkg::GROUP_BITS;
    localparam int CB       = dtq_pkg::COUNT_BITS;

    logic [PAD_BITS-1:0] padded;
    logic [GB-1:0]       grp_next [dtq_pkg::GROUPS];
    logic [GB-1:0]       grp_reg  [dtq_pkg::GROUPS];

    assign padded = PAD_BITS'(flags);

    always_comb begin
        for (int g = 0; g < dtq_pkg::GROUPS; g++) begin
            grp_next[g] = '0;
            for (int b = 0; b < dtq_pkg::GROUP_SIZE; b++) begin
                grp_next[g] = grp_next[g] + GB'(padded[g * dtq_pkg::GROUP_SIZE + b]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < dtq_pkg::GROUPS; g++) begin
            grp_reg[g] <= grp_next[g];
        end
    end

    always_comb begin
        total = '0;
        for (int g = 0; g < dtq_pkg::GROUPS; g++) begin
            total = total + CB'(grp_reg[g]);
        end
    end

endmodule

`default_nettype wire
